### sv/sfl_pkg.sv
// Shared types and constants for the slot allocator free list.
package sfl_pkg;

    // Slot indices travel in 8-bit fields, so the usable pool is capped at 256.
    localparam int unsigned SLOT_W        = 8;
    localparam int unsigned STATUS_W      = 2;
    localparam int unsigned POOL_MAX      = 256;
    localparam int unsigned SLOTS_DEFAULT = 256;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_REJECT = 2'd2;

    // Broadcast control from the allocator to every cell in the row.
    typedef struct packed {
        logic              push;
        logic              pop;
        logic              mark_set;
        logic              mark_clr;
        logic [SLOT_W-1:0] mark_slot;
    } cell_ctrl_t;

endpackage

### sv/sfl_cell.sv
// One cell of the row: a free stack entry and the in-use bit of one slot.
module sfl_cell #(
    parameter logic [sfl_pkg::SLOT_W-1:0] CELL_IDX = '0
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  sfl_pkg::cell_ctrl_t        ctrl,
    input  logic [sfl_pkg::SLOT_W-1:0] up_entry,
    input  logic [sfl_pkg::SLOT_W-1:0] down_entry,
    output logic [sfl_pkg::SLOT_W-1:0] entry,
    output logic                       used
);
    import sfl_pkg::*;

    logic [SLOT_W-1:0] entry_reg;
    logic [SLOT_W-1:0] entry_next;
    logic              used_reg;
    logic              used_next;

    // A push moves every entry one cell deeper; a pop moves them one cell up.
    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.push)
        begin
            entry_next = up_entry;
        end
        else if (ctrl.pop)
        begin
            entry_next = down_entry;
        end
    end

    always_comb
    begin
        used_next = used_reg;
        if (ctrl.mark_set && (ctrl.mark_slot == CELL_IDX))
        begin
            used_next = 1'b1;
        end
        else if (ctrl.mark_clr && (ctrl.mark_slot == CELL_IDX))
        begin
            used_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
        end
        else
        begin
            used_reg <= used_next;
        end
    end

    assign entry = entry_reg;
    assign used  = used_reg;

endmodule

### sv/slot_allocator_free_list.sv
// Top level of the slot allocator: command decode, counters and the row of cells.
//
// This block hands out and takes back slot indices from a pool of SLOTS entries
// (capped at 256, since slots travel in 8-bit fields). An allocate command first
// pops the most recently freed slot from a LIFO free stack; when that stack is
// empty it hands out the next never-used slot from a bump counter, and when both
// are exhausted it answers with status 1 (pool full). A free command is taken only
// for a slot that is currently in use; it clears the in-use mark and pushes the
// slot onto the stack. A free of an idle or out-of-range slot answers with status
// 2 and leaves the state alone. Every command gives exactly one result item, with
// slot_out zero except for a granted allocate. The free stack and the in-use map
// live in a row of identical cells: cell N holds stack entry N (the top of the
// stack is cell 0) and the in-use bit of slot N, and on a push or pop every cell
// hands its entry to its neighbor in the same cycle. A command's result is decided
// from the counters, the top cell and the in-use bit of the named slot, and lands
// in the output register at the accepting edge. One command per cycle is
// sustained; the input stalls only while a finished result waits in the output
// register and the downstream side is not taking it. The in-use bits clear at
// reset at once, so no clearing pass is needed.
module slot_allocator_free_list #(
    parameter int unsigned SLOTS = sfl_pkg::SLOTS_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [sfl_pkg::SLOT_W-1:0]   s_tdata,   // [7:0] slot
    input  logic                         s_tuser,   // [0] command
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [sfl_pkg::SLOT_W-1:0]   m_tdata,   // [7:0] slot_out
    output logic [sfl_pkg::STATUS_W-1:0] m_tuser    // [1:0] status
);
    import sfl_pkg::*;

    localparam int unsigned POOL  = (SLOTS < POOL_MAX) ? SLOTS : POOL_MAX;
    localparam int unsigned CNT_W = $clog2(POOL + 1);
    localparam int unsigned IDX_W = $clog2(POOL);
    localparam logic [SLOT_W:0]  POOL_LIM = (SLOT_W + 1)'(POOL);
    localparam logic [CNT_W-1:0] POOL_CNT = CNT_W'(POOL);

    logic [CNT_W-1:0]    free_count_reg;
    logic [CNT_W-1:0]    free_count_next;
    logic [CNT_W-1:0]    next_fresh_reg;
    logic [CNT_W-1:0]    next_fresh_next;
    logic                m_tvalid_reg;
    logic                m_tvalid_next;
    logic [SLOT_W-1:0]   m_tdata_reg;
    logic [SLOT_W-1:0]   m_tdata_next;
    logic [STATUS_W-1:0] m_tuser_reg;
    logic [STATUS_W-1:0] m_tuser_next;

    logic                accept;
    logic                have_free;
    logic                have_fresh;
    logic                in_range;
    logic                slot_used;
    logic                take_fresh;
    logic [SLOT_W-1:0]   grant_slot;
    logic [STATUS_W-1:0] status;
    cell_ctrl_t          ctrl;

    logic [SLOT_W-1:0]   entry_arr [POOL];
    logic [SLOT_W-1:0]   up_arr    [POOL];
    logic [SLOT_W-1:0]   down_arr  [POOL];
    logic [POOL-1:0]     used_vec;

    // The output register parts the two sides; a held result blocks only while
    // the downstream side is stalled.
    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign have_free  = (free_count_reg != '0);
    assign have_fresh = (next_fresh_reg < POOL_CNT);
    assign in_range   = ({1'b0, s_tdata} < POOL_LIM);
    assign slot_used  = in_range && used_vec[s_tdata[IDX_W-1:0]];

    // Decide the outcome of the offered command from the current state.
    always_comb
    begin
        ctrl       = '0;
        take_fresh = 1'b0;
        grant_slot = '0;
        status     = ST_OK;
        if (s_tuser == CMD_ALLOC)
        begin
            if (have_free)
            begin
                ctrl.pop   = 1'b1;
                grant_slot = entry_arr[0];
            end
            else if (have_fresh)
            begin
                take_fresh = 1'b1;
                grant_slot = SLOT_W'(next_fresh_reg);
            end
            else
            begin
                status = ST_FULL;
            end
            ctrl.mark_set  = (status == ST_OK);
            ctrl.mark_slot = grant_slot;
        end
        else
        begin
            if (slot_used)
            begin
                ctrl.push      = 1'b1;
                ctrl.mark_clr  = 1'b1;
                ctrl.mark_slot = s_tdata;
            end
            else
            begin
                status = ST_REJECT;
            end
        end
        if (!accept)
        begin
            ctrl       = '0;
            take_fresh = 1'b0;
        end
    end

    always_comb
    begin
        free_count_next = free_count_reg;
        next_fresh_next = next_fresh_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;
        if (ctrl.pop)
        begin
            free_count_next = free_count_reg - CNT_W'(1);
        end
        else if (ctrl.push)
        begin
            free_count_next = free_count_reg + CNT_W'(1);
        end
        if (take_fresh)
        begin
            next_fresh_next = next_fresh_reg + CNT_W'(1);
        end
        if (accept)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = grant_slot;
            m_tuser_next  = status;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_count_reg <= '0;
            next_fresh_reg <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            free_count_reg <= free_count_next;
            next_fresh_reg <= next_fresh_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // The row of cells. Cell 0 takes the freed slot on a push; the last cell
    // keeps its own entry on a pop, since nothing lies below it.
    for (genvar i = 0; i < POOL; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            assign up_arr[i] = s_tdata;
        end
        else
        begin : g_body
            assign up_arr[i] = entry_arr[i-1];
        end

        if (i == POOL - 1)
        begin : g_tail
            assign down_arr[i] = entry_arr[i];
        end
        else
        begin : g_link
            assign down_arr[i] = entry_arr[i+1];
        end

        sfl_cell #(
            .CELL_IDX (SLOT_W'(i))
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .up_entry   (up_arr[i]),
            .down_entry (down_arr[i]),
            .entry      (entry_arr[i]),
            .used       (used_vec[i])
        );
    end

`ifndef SYNTHESIS
    // Every slot handed out so far is either in use or on the free stack.
    a_slot_balance: assert property (@(posedge clk) disable iff (!rst_n)
        (int'($countones(used_vec)) + int'(free_count_reg)) == int'(next_fresh_reg))
        else $error("in-use count plus stack depth differs from slots handed out");

    a_fresh_bound: assert property (@(posedge clk) disable iff (!rst_n)
        next_fresh_reg <= POOL_CNT)
        else $error("bump counter ran past the pool");

    a_grant_marked: assert property (@(posedge clk) disable iff (!rst_n)
        accept && ctrl.mark_set |=> used_vec[$past(grant_slot[IDX_W-1:0])])
        else $error("granted slot not marked in use");

    a_free_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        accept && ctrl.mark_clr |=> !used_vec[$past(s_tdata[IDX_W-1:0])]
            && (entry_arr[0] == $past(s_tdata)))
        else $error("freed slot still marked or not on top of the stack");

    a_fail_zero_slot: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg && (m_tuser_reg != ST_OK) |-> (m_tdata_reg == '0))
        else $error("failed command reports a nonzero slot");
`endif

endmodule

### bench/slot_allocator_free_list_checker.sv
// Watches both streams of the slot allocator, predicts each result and compares it.
`timescale 1ns / 100ps

module slot_allocator_free_list_checker
    import sfl_pkg::*;
#(
    parameter int unsigned SLOTS = SLOTS_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [SLOT_W-1:0]   s_tdata,    // [7:0] slot
    input  logic                s_tuser,    // [0] command
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [SLOT_W-1:0]   m_tdata,    // [7:0] slot_out
    input  logic [STATUS_W-1:0] m_tuser,    // [1:0] status
    input  logic                run_done,
    output int unsigned         mismatches,
    output int unsigned         outstanding
);

    localparam int unsigned POOL = (SLOTS < POOL_MAX) ? SLOTS : POOL_MAX;

    typedef struct packed {
        logic [SLOT_W-1:0]   slot;
        logic [STATUS_W-1:0] status;
    } grant_t;

    // Private copy of the allocator state.
    logic [SLOT_W-1:0] free_slots [POOL_MAX];
    logic [8:0]        stack_depth;
    logic [8:0]        fresh_next;
    bit                busy [POOL_MAX];

    grant_t expected_grants [$];

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        $display("%0t ns: %s: expected %0d, got %0d", $time, what, want, got);
        mismatches++;
    endtask

    // Applies one command to the private state and returns the grant it yields.
    function automatic grant_t apply_command(input logic cmd, input logic [SLOT_W-1:0] slot);
        grant_t g;
        g.slot   = '0;
        g.status = ST_OK;
        if (cmd == CMD_ALLOC)
        begin
            if (stack_depth != 0)
            begin
                stack_depth = stack_depth - 9'd1;
                g.slot = free_slots[stack_depth[7:0]];
                busy[g.slot] = 1'b1;
            end
            else if (fresh_next < POOL)
            begin
                g.slot = fresh_next[7:0];
                fresh_next = fresh_next + 9'd1;
                busy[g.slot] = 1'b1;
            end
            else
                g.status = ST_FULL;
        end
        else if (slot >= POOL || !busy[slot])
            g.status = ST_REJECT;
        else
        begin
            busy[slot] = 1'b0;
            if (stack_depth < POOL_MAX)
            begin
                free_slots[stack_depth[7:0]] = slot;
                stack_depth = stack_depth + 9'd1;
            end
        end
        return g;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        grant_t want;
        if (!rst_n)
        begin
            stack_depth = '0;
            fresh_next  = '0;
            for (int i = 0; i < POOL_MAX; i++)
                busy[i] = 1'b0;
            expected_grants.delete();
            mismatches = 0;
        end
        else
        begin
            // A command and a result can pass in the same cycle; queue first so that
            // a result passing with its own command would still find its expectation.
            if (s_tvalid && s_tready)
                expected_grants = {expected_grants, apply_command(s_tuser, s_tdata)};
            if (m_tvalid && m_tready)
            begin
                if (expected_grants.size() == 0)
                    report_mismatch("result with no command waiting", 0, 32'(m_tdata));
                else
                begin
                    want = expected_grants.pop_front();
                    if (m_tdata !== want.slot)
                        report_mismatch("slot_out", 32'(want.slot), 32'(m_tdata));
                    if (m_tuser !== want.status)
                        report_mismatch("status", 32'(want.status), 32'(m_tuser));
                end
            end
            // The end of the run is a one-cycle pulse on run_done.
            if (run_done && expected_grants.size() != 0)
                report_mismatch("results never delivered", 0, expected_grants.size());
        end
        outstanding = expected_grants.size();
    end

endmodule

### bench/slot_allocator_free_list_tb.sv
// Top of the slot allocator bench: clock, reset, stimulus, flow control and verdict.
`timescale 1ns / 100ps

module slot_allocator_free_list_tb;

    import sfl_pkg::*;

    // The run is split into three flow-control phases by item count.
    localparam int unsigned PHASE2_AT   = 320;
    localparam int unsigned PHASE3_AT   = 640;
    // The long receiver hold-off falls in the phase where the sender never idles,
    // so the block is sure to fill up and drop s_tready.
    localparam int unsigned HOLD_AT     = 720;
    localparam int unsigned HOLD_CYCLES = 48;
    localparam int unsigned FILL_ITEMS  = 260;
    localparam int unsigned RAND_ITEMS  = 670;
    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned TAIL_CYCLES = 16;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [SLOT_W-1:0]   s_tdata;     // [7:0] slot
    logic                s_tuser;     // [0] command
    logic                m_tvalid;
    logic                m_tready;
    logic [SLOT_W-1:0]   m_tdata;     // [7:0] slot_out
    logic [STATUS_W-1:0] m_tuser;     // [1:0] status
    logic                run_done;
    int unsigned         mismatches;
    int unsigned         outstanding;

    int unsigned         items_sent  = 0;
    int unsigned         tx_idle_pct = 12;
    int unsigned         rx_idle_pct = 55;

    always #10 clk = ~clk;

    slot_allocator_free_list i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    slot_allocator_free_list_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .run_done    (run_done),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // Offers one command item, with random idle cycles in front of it, and returns
    // at the edge where the block takes it. Between back-to-back items tvalid stays
    // high, so it only ever gets one assignment per edge.
    task automatic send_item(input logic cmd, input logic [SLOT_W-1:0] slot);
        if (items_sent < PHASE2_AT)
        begin
            tx_idle_pct = 12;
            rx_idle_pct = 55;
        end
        else if (items_sent < PHASE3_AT)
        begin
            tx_idle_pct = 55;
            rx_idle_pct = 12;
        end
        else
        begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= slot;
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
        items_sent++;
    endtask

    // Receiver side: random back-pressure, plus one long hold-off while the sender
    // keeps offering items.
    initial
    begin
        int unsigned hold_left;
        bit          held_off;
        hold_left = 0;
        held_off  = 1'b0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left != 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (!held_off && items_sent >= HOLD_AT)
            begin
                held_off  = 1'b1;
                hold_left = HOLD_CYCLES;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Watchdog: ends the run if neither stream moves an item for too long.
    initial
    begin
        int unsigned stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("slot_allocator_free_list_tb failed");
        $finish;
    end

    initial
    begin
        int unsigned      alloc_pct;
        int unsigned      waited;
        logic [SLOT_W-1:0] pick;
        logic [SLOT_W-1:0] last_freed;
        alloc_pct  = 15;
        waited     = 0;
        last_freed = '0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= CMD_ALLOC;
        run_done <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. The first allocations come from the bump counter, frees
        // push onto the stack and later allocations must pop them in LIFO order.
        send_item(CMD_ALLOC, 8'hFF);    // slot field is ignored on allocate
        send_item(CMD_ALLOC, 8'h00);
        send_item(CMD_ALLOC, 8'h5A);
        send_item(CMD_FREE,  8'd1);     // accepted free
        send_item(CMD_FREE,  8'd1);     // double free is rejected
        send_item(CMD_FREE,  8'hFF);    // free of a slot never handed out
        send_item(CMD_FREE,  8'd0);
        send_item(CMD_ALLOC, 8'hA5);    // pops slot 0, the most recent free
        send_item(CMD_ALLOC, 8'h00);    // pops slot 1
        send_item(CMD_ALLOC, 8'hFF);    // stack empty again, fresh slot 3
        send_item(CMD_FREE,  8'd3);
        send_item(CMD_FREE,  8'd2);
        send_item(CMD_FREE,  8'd0);
        send_item(CMD_FREE,  8'd0);     // idle again after its free
        send_item(CMD_ALLOC, 8'h0F);
        send_item(CMD_ALLOC, 8'hF0);
        send_item(CMD_ALLOC, 8'h80);
        send_item(CMD_FREE,  8'd128);   // idle slot in the upper half
        send_item(CMD_FREE,  8'd4);     // one past the highest slot handed out

        // Run the pool dry: more allocations than slots, so the last few report full.
        repeat (FILL_ITEMS)
            send_item(CMD_ALLOC, SLOT_W'($urandom_range(0, 255)));

        // Random part in segments with a changing mix of allocates and frees. The
        // first segment is free-heavy so that the full pool drains through the stack.
        for (int k = 0; k < RAND_ITEMS; k++)
        begin
            if (k != 0 && k % 64 == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       alloc_pct = 15;
                    1:       alloc_pct = 50;
                    default: alloc_pct = 85;
                endcase
            end
            if ($urandom_range(0, 99) < alloc_pct)
                send_item(CMD_ALLOC, SLOT_W'($urandom_range(0, 255)));
            else
            begin
                // Now and then repeat the previous free to provoke a double free.
                if ($urandom_range(0, 9) == 0)
                    pick = last_freed;
                else
                    pick = SLOT_W'($urandom_range(0, 255));
                last_freed = pick;
                send_item(CMD_FREE, pick);
            end
        end
        s_tvalid <= 1'b0;

        // Drain: wait for every expected result, then let the output settle.
        do
        begin
            @(negedge clk);
            waited++;
        end
        while (outstanding != 0 && waited < STALL_LIMIT);
        repeat (TAIL_CYCLES) @(posedge clk);
        // One-cycle pulse: the checker looks for undelivered results at one edge.
        run_done <= 1'b1;
        @(posedge clk);
        run_done <= 1'b0;
        @(negedge clk);

        if (mismatches == 0)
            $display("slot_allocator_free_list_tb passed");
        else
            $display("slot_allocator_free_list_tb failed");
        $finish;
    end

endmodule
